// ===== rtl/tsv_quoted_field_parser_top_defines.svh =====
// ----------------------------------------------------------------------------
// TSV quoted-field parser assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef TSV_QUOTED_FIELD_PARSER_TOP_DEFINES_SVH
`define TSV_QUOTED_FIELD_PARSER_TOP_DEFINES_SVH

// condition holds at every edge outside reset
`define TQFP_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tqfp assertion failed");

// consequent holds at the next edge after antecedent
`define TQFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tqfp assertion failed");

`endif

// ===== rtl/tqfp_pkg.sv =====
// ----------------------------------------------------------------------------
// tqfp_pkg
// Types and constants shared by the TSV quoted-field parser modules.
// ----------------------------------------------------------------------------
package tqfp_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;

    localparam logic [BYTE_W-1:0] BYTE_LF       = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] DELIM_RESET   = 8'h09;
    localparam logic [BYTE_W-1:0] QUOTE_RESET   = 8'h22;

    // configuration register indexes
    localparam logic CFG_DELIMITER = 1'b0;
    localparam logic CFG_QUOTE     = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIELD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECORD = 2'd2;

    typedef struct packed {
        logic inside_quotes;
        logic quote_seen_in_quotes;
        logic field_was_quoted;
        logic field_has_bytes;
        logic separator_in_record;
        logic record_has_input;
        logic swallow_next_lf;
        logic swallow_lf_in_quotes;
    } parse_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] item_kind;
        logic [BYTE_W-1:0] content_byte;
    } result_t;

endpackage

// ===== rtl/tsv_quoted_field_parser_top.sv =====
// ----------------------------------------------------------------------------
// tsv_quoted_field_parser_top
// Byte-stream parser for tab-separated text with quoted fields.
// ----------------------------------------------------------------------------
// Input beats: one text byte on s_axis_tdata, or an end-of-input mark with
// s_axis_tlast high (tdata then ignored). Output beats: m_axis_tuser gives
// the kind (content byte, end of field, end of field and record) and
// m_axis_tdata the content byte, zero for the two end marks. A beat may give
// no output (quotes, blank records, LF after CR).
// Throughput: one input beat per cycle while s_axis_tready is high. Output
// beats are registered: each result goes from the per-byte decision logic
// into the output register, or into the skid entry if that is busy.
// When the receiver stalls, one more result is held in a skid entry; once it
// is occupied s_axis_tready drops until the output register drains.
// The user writes delimiter and quote bytes on cfg_we/cfg_index/cfg_data
// only while the block is idle, which it does not enforce. Reset restores
// tab and double quote and clears all parse state and both output entries.
// ----------------------------------------------------------------------------
module tsv_quoted_field_parser_top
    import tqfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] in_byte
    input  logic              s_axis_tlast,   // end_of_input
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] content_byte
    output logic [1:0]        m_axis_tuser    // [1:0] item_kind
);

    logic    in_accept;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    tqfp_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_accept    (in_accept),
        .in_byte      (s_axis_tdata),
        .end_of_input (s_axis_tlast),
        .res_valid    (res_valid),
        .res          (res)
    );

    tqfp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .can_accept (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (out_data)
    );

    assign m_axis_tdata = out_data.content_byte;
    assign m_axis_tuser = out_data.item_kind;

endmodule

// ===== rtl/tqfp_core.sv =====
// ----------------------------------------------------------------------------
// tqfp_core
// Parser state, configuration registers and per-byte decision logic.
// ----------------------------------------------------------------------------
`include "tsv_quoted_field_parser_top_defines.svh"

module tqfp_core
    import tqfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    input  logic              in_accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              end_of_input,
    output logic              res_valid,
    output result_t           res
);

    logic [BYTE_W-1:0] delimiter_reg;
    logic [BYTE_W-1:0] quote_reg;
    parse_state_t      state_reg;
    parse_state_t      state_next;
    logic              emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= DELIM_RESET;
            quote_reg     <= QUOTE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DELIMITER)
                delimiter_reg <= cfg_data;
            else
                quote_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (in_accept)
            state_reg <= state_next;
    end

    always_comb
    begin
        logic dropped;
        logic unquoted;
        logic is_quote;
        logic is_eol;

        state_next = state_reg;
        emit       = 1'b0;
        res        = '{item_kind: KIND_BYTE, content_byte: '0};
        dropped    = 1'b0;
        unquoted   = 1'b0;
        is_quote   = (in_byte == quote_reg);
        is_eol     = (in_byte == BYTE_LF) || (in_byte == BYTE_CR);

        if (end_of_input)
        begin
            emit          = state_reg.record_has_input;
            res.item_kind = KIND_RECORD;
            state_next    = '0;
        end
        else
        begin
            // LF right after a CR is dropped: the CR already ended the record or gave the quoted LF
            dropped = (state_reg.swallow_next_lf || state_reg.swallow_lf_in_quotes)
                      && (in_byte == BYTE_LF);
            state_next.swallow_next_lf      = 1'b0;
            state_next.swallow_lf_in_quotes = 1'b0;

            if (!dropped)
            begin
                state_next.record_has_input = 1'b1;
                unquoted = !state_reg.inside_quotes;

                if (state_reg.inside_quotes)
                begin
                    if (state_reg.quote_seen_in_quotes)
                    begin
                        state_next.quote_seen_in_quotes = 1'b0;
                        if (is_quote)
                        begin
                            emit             = 1'b1;
                            res.content_byte = in_byte;
                            state_next.field_has_bytes = 1'b1;
                        end
                        else
                        begin
                            // closing quote; this byte falls through as unquoted
                            state_next.inside_quotes = 1'b0;
                            unquoted = 1'b1;
                        end
                    end
                    else if (is_quote)
                        state_next.quote_seen_in_quotes = 1'b1;
                    else if (in_byte == BYTE_CR)
                    begin
                        state_next.swallow_lf_in_quotes = 1'b1;
                        state_next.field_has_bytes      = 1'b1;
                        emit             = 1'b1;
                        res.content_byte = BYTE_LF;
                    end
                    else
                    begin
                        state_next.field_has_bytes = 1'b1;
                        emit             = 1'b1;
                        res.content_byte = in_byte;
                    end
                end

                if (unquoted)
                begin
                    if (in_byte == delimiter_reg)
                    begin
                        state_next.field_has_bytes     = 1'b0;
                        state_next.field_was_quoted    = 1'b0;
                        state_next.separator_in_record = 1'b1;
                        emit          = 1'b1;
                        res.item_kind = KIND_FIELD;
                    end
                    else if (is_eol)
                    begin
                        // blank record: no separator and no content
                        emit = state_reg.separator_in_record || state_next.field_has_bytes;
                        res.item_kind = KIND_RECORD;
                        state_next = '0;
                        state_next.swallow_next_lf = (in_byte == BYTE_CR);
                    end
                    else if (is_quote && !state_next.field_has_bytes
                             && !state_reg.field_was_quoted)
                    begin
                        state_next.inside_quotes    = 1'b1;
                        state_next.field_was_quoted = 1'b1;
                    end
                    else
                    begin
                        state_next.field_has_bytes = 1'b1;
                        emit             = 1'b1;
                        res.content_byte = in_byte;
                    end
                end
            end
        end
    end

    assign res_valid = in_accept && emit;

    `TQFP_ASSERT_NEXT(a_eoi_clears, in_accept && end_of_input, state_reg == '0)
    `TQFP_ASSERT_ALWAYS(a_one_swallow,
        !(state_reg.swallow_next_lf && state_reg.swallow_lf_in_quotes))
    `TQFP_ASSERT_ALWAYS(a_quote_seen_inside,
        !state_reg.quote_seen_in_quotes || state_reg.inside_quotes)

endmodule

// ===== rtl/tqfp_out_stage.sv =====
// ----------------------------------------------------------------------------
// tqfp_out_stage
// Output register with one skid entry; upstream ready is a registered flag.
// ----------------------------------------------------------------------------
`include "tsv_quoted_field_parser_top_defines.svh"

module tqfp_out_stage
    import tqfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    can_accept,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop        = out_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            // skid full means no push this cycle
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        else if (push)
            skid_data_reg <= push_data;
    end

    `TQFP_ASSERT_ALWAYS(a_skid_needs_out, !skid_valid_reg || out_valid_reg)
    `TQFP_ASSERT_ALWAYS(a_no_push_when_full, !(push && skid_valid_reg))
    `TQFP_ASSERT_NEXT(a_skid_moves_up, skid_valid_reg && out_ready,
        out_valid_reg && !skid_valid_reg)

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: TSV quoted-field parser testbench
// Streams text bytes and end-of-input beats through the parser under several
// delimiter/quote settings. A scoreboard tracks the parse state, predicts
// content, end-of-field and end-of-record beats, and checks each output beat
// in order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import tqfp_pkg::*;

    class tsv_token_scoreboard;
        logic [BYTE_W-1:0] delim_char = DELIM_RESET;
        logic [BYTE_W-1:0] quote_char = QUOTE_RESET;
        parse_state_t      st = '0;
        result_t           expected_tokens[$];
        int                mismatches = 0;

        task report(input string msg);
            mismatches++;
            $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        function bit content_token(input logic [BYTE_W-1:0] b, output result_t tok);
            st.field_has_bytes = 1'b1;
            tok.item_kind      = KIND_BYTE;
            tok.content_byte   = b;
            return 1'b1;
        endfunction

        // one text byte through the parse rules; returns 1 when a token comes out
        function bit parse_byte(input logic [BYTE_W-1:0] b, output result_t tok);
            bit skip;
            tok = '0;
            if (st.swallow_next_lf) begin
                st.swallow_next_lf = 1'b0;
                if (b == BYTE_LF)
                    return 1'b0;
            end
            if (st.swallow_lf_in_quotes) begin
                st.swallow_lf_in_quotes = 1'b0;
                if (b == BYTE_LF)
                    return 1'b0;
            end
            st.record_has_input = 1'b1;

            if (st.inside_quotes) begin
                if (st.quote_seen_in_quotes) begin
                    st.quote_seen_in_quotes = 1'b0;
                    if (b == quote_char)
                        return content_token(b, tok);
                    // closing quote: this byte falls through as unquoted
                    st.inside_quotes = 1'b0;
                end
                else if (b == quote_char) begin
                    st.quote_seen_in_quotes = 1'b1;
                    return 1'b0;
                end
                else if (b == BYTE_CR) begin
                    st.swallow_lf_in_quotes = 1'b1;
                    return content_token(BYTE_LF, tok);
                end
                else begin
                    return content_token(b, tok);
                end
            end

            if (b == delim_char) begin
                st.field_has_bytes     = 1'b0;
                st.field_was_quoted    = 1'b0;
                st.separator_in_record = 1'b1;
                tok.item_kind          = KIND_FIELD;
                return 1'b1;
            end
            if (b == BYTE_LF || b == BYTE_CR) begin
                skip               = !st.separator_in_record && !st.field_has_bytes;
                st                 = '0;
                st.swallow_next_lf = (b == BYTE_CR);
                tok.item_kind      = KIND_RECORD;
                return !skip;
            end
            if (b == quote_char && !st.field_has_bytes && !st.field_was_quoted) begin
                st.inside_quotes    = 1'b1;
                st.field_was_quoted = 1'b1;
                return 1'b0;
            end
            return content_token(b, tok);
        endfunction

        function void take_beat(input logic [BYTE_W-1:0] b, input logic eoi);
            result_t tok;
            if (eoi) begin
                if (st.record_has_input) begin
                    tok           = '0;
                    tok.item_kind = KIND_RECORD;
                    expected_tokens.push_back(tok);
                end
                st = '0;
            end
            else if (parse_byte(b, tok)) begin
                expected_tokens.push_back(tok);
            end
        endfunction

        task check_token(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data);
            result_t exp_tok;
            if (expected_tokens.size() == 0) begin
                report($sformatf("output beat with nothing expected: kind %0d data %02h",
                                 kind, data));
                return;
            end
            exp_tok = expected_tokens.pop_front();
            if (kind !== exp_tok.item_kind)
                report($sformatf("item_kind %0d, expected %0d", kind, exp_tok.item_kind));
            if (data !== exp_tok.content_byte)
                report($sformatf("content_byte %02h, expected %02h",
                                 data, exp_tok.content_byte));
        endtask
    endclass

    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 240;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_we        = 1'b0;
    logic              cfg_index     = CFG_DELIMITER;
    logic [BYTE_W-1:0] cfg_data      = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;   // [7:0] in_byte
    logic              s_axis_tlast  = 1'b0; // end_of_input
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;         // [7:0] content_byte
    logic [1:0]        m_axis_tuser;         // [1:0] item_kind

    tsv_token_scoreboard sb = new;
    int                  beats_sent = 0;
    bit                  tx_steady  = 1'b0;
    bit                  rx_steady  = 1'b0;

    tsv_quoted_field_parser_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 clk = ~clk;

    task automatic send_beat(input logic [7:0] b, input logic eoi);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eoi;
        do @(posedge clk); while (!s_axis_tready);
        sb.take_beat(b, eoi);
        beats_sent++;
    endtask

    // byte that is none of delimiter, quote, CR, LF under the current setting
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == sb.delim_char || b == sb.quote_char || b == BYTE_CR || b == BYTE_LF);
        return b;
    endfunction

    task automatic send_record();
        int nfields;
        int len;
        int pick;
        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++) begin
            if (f > 0)
                send_beat(sb.delim_char, 1'b0);
            len = $urandom_range(0, 5);
            if ($urandom_range(0, 1)) begin
                send_beat(sb.quote_char, 1'b0);
                repeat (len) begin
                    pick = $urandom_range(0, 19);
                    case (pick)
                        0, 1: begin
                            send_beat(sb.quote_char, 1'b0);
                            send_beat(sb.quote_char, 1'b0);
                        end
                        2: send_beat(BYTE_CR, 1'b0);
                        3: begin
                            send_beat(BYTE_CR, 1'b0);
                            send_beat(BYTE_LF, 1'b0);
                        end
                        4: send_beat(BYTE_LF, 1'b0);
                        5: send_beat(sb.delim_char, 1'b0);
                        default: send_beat(plain_byte(), 1'b0);
                    endcase
                end
                send_beat(sb.quote_char, 1'b0);
                // stray text after the closing quote
                if ($urandom_range(0, 15) == 0)
                    send_beat(plain_byte(), 1'b0);
            end
            else begin
                repeat (len)
                    send_beat(($urandom_range(0, 9) == 0) ? sb.quote_char : plain_byte(), 1'b0);
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 3)
            send_beat(BYTE_LF, 1'b0);
        else if (pick < 6)
            send_beat(BYTE_CR, 1'b0);
        else if (pick < 9) begin
            send_beat(BYTE_CR, 1'b0);
            send_beat(BYTE_LF, 1'b0);
        end
        else
            send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            if ($urandom_range(0, 7) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'b1);
            else
                send_beat(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_tokens.size() != 0)
            @(posedge clk);
        // beats that produce nothing may still be in flight
        repeat (6) @(posedge clk);
    endtask

    task automatic write_setting(input logic [7:0] delim, input logic [7:0] quote);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DELIMITER;
        cfg_data  <= delim;
        @(posedge clk);
        sb.delim_char = delim;
        cfg_index <= CFG_QUOTE;
        cfg_data  <= quote;
        @(posedge clk);
        sb.quote_char = quote;
        cfg_we <= 1'b0;
    endtask

    // receiver: stall before each beat, with steady stretches
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_token(m_axis_tuser, m_axis_tdata);
    end

    initial begin
        // {end_of_input, byte}
        logic [8:0] directed [24];
        logic [7:0] delim_set [PHASES];
        logic [7:0] quote_set [PHASES];
        int         target;

        directed = '{9'h000, 9'h0FF, 9'h009, 9'h022, 9'h078, 9'h022, 9'h022, 9'h00D,
                     9'h00A, 9'h022, 9'h00D, 9'h00A, 9'h00A, 9'h022, 9'h022, 9'h00A,
                     9'h061, 9'h022, 9'h100, 9'h100, 9'h022, 9'h15A, 9'h009, 9'h1FF};
        delim_set = '{DELIM_RESET, 8'h00, 8'hFF, 8'h2C, BYTE_CR, BYTE_LF, 8'h00, 8'h00};
        quote_set = '{QUOTE_RESET, 8'hFF, 8'h00, 8'h27, BYTE_LF, BYTE_CR, 8'h00, 8'h00};
        delim_set[6] = 8'($urandom_range(0, 255));
        quote_set[6] = 8'($urandom_range(0, 255));
        // delimiter and quote on the same byte
        delim_set[7] = 8'($urandom_range(0, 255));
        quote_set[7] = delim_set[7];

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: field/record marks, doubled quote, CR in quotes,
        // CRLF, blank records, lone quoted empty field, end of input cases
        foreach (directed[i])
            send_beat(directed[i][7:0], directed[i][8]);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_setting(delim_set[p], quote_set[p]);
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target) begin
                if ($urandom_range(0, 99) < 85)
                    send_record();
                else
                    send_noise();
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_tokens.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tqfp_pkg.sv
rtl/tqfp_core.sv
rtl/tqfp_out_stage.sv
rtl/tsv_quoted_field_parser_top.sv
bench/tb.sv
